[sv/kbfa_pkg.sv]
// ----------------------------------------------------------------------------
// kbfa_pkg
// Types and constants shared by the keyed best-fit region allocator.
// ----------------------------------------------------------------------------
package kbfa_pkg;

  localparam logic [1:0] FN_LOOKUP = 2'd0;
  localparam logic [1:0] FN_STORE  = 2'd1;
  localparam logic [1:0] FN_REMOVE = 2'd2;

  localparam logic [1:0] CFG_BASE_OFFSET     = 2'd0;
  localparam logic [1:0] CFG_POOL_SIZE       = 2'd1;
  localparam logic [1:0] CFG_SPLIT_THRESHOLD = 2'd2;

  localparam int unsigned CFG_DW = 31;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_NO_SPACE  = 3'd3,
    ST_BAD       = 3'd4
  } status_e;

  typedef struct packed {
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [30:0] offset;
    logic [30:0] size;
  } entry_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [30:0] request_size;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [5:0]  slot_index;
    logic [30:0] region_offset;
    logic [30:0] region_size;
  } res_t;

  typedef struct packed {
    logic [20:0] base_offset;
    logic [30:0] pool_size;
    logic [30:0] split_threshold;
  } cfg_t;

endpackage

[sv/kbfa_if.sv]
// ----------------------------------------------------------------------------
// kbfa_in_if / kbfa_out_if
// Valid/ready channels for allocator requests and results.
// ----------------------------------------------------------------------------
interface kbfa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [63:0] key_high;
  logic [63:0] key_low;
  logic [30:0] request_size;

  modport source (output valid, func, key_high, key_low, request_size, input ready);
  modport sink (input valid, func, key_high, key_low, request_size, output ready);
endinterface

interface kbfa_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [5:0]  slot_index;
  logic [30:0] region_offset;
  logic [30:0] region_size;

  modport source (output valid, status, slot_index, region_offset, region_size, input ready);
  modport sink (input valid, status, slot_index, region_offset, region_size, output ready);
endinterface

[sv/keyed_best_fit_region_allocator.sv]
// ----------------------------------------------------------------------------
// keyed_best_fit_region_allocator
// Handles one request at a time; every table pass visits one entry at a
//   time through the one-write one-read registered-read table RAM.
// Reset: one free region at base_offset of pool_size; a base or pool write
//   rebuilds the table the same way.
// ----------------------------------------------------------------------------
module keyed_best_fit_region_allocator #(
  parameter int unsigned SLOTS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  kbfa_in_if.sink                     in_i,
  kbfa_out_if.source                  out_o,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [kbfa_pkg::CFG_DW-1:0] cfg_data_i
);
  import kbfa_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic init_q, init_d;
  req_t req;
  res_t res;

  always_comb begin
    cfg_d  = cfg_q;
    init_d = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BASE_OFFSET: begin
          cfg_d.base_offset = cfg_data_i[20:0];
          init_d            = 1'b1;
        end
        CFG_POOL_SIZE: begin
          cfg_d.pool_size = cfg_data_i[30:0];
          init_d          = 1'b1;
        end
        CFG_SPLIT_THRESHOLD: begin
          cfg_d.split_threshold = cfg_data_i[30:0];
        end
        default: begin
          init_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_offset     <= 21'd1536;
      cfg_q.pool_size       <= 31'd1073741824;
      cfg_q.split_threshold <= 31'd1024;
      init_q                <= 1'b0;
    end else begin
      cfg_q  <= cfg_d;
      init_q <= init_d;
    end
  end

  assign req.func         = in_i.func;
  assign req.key_high     = in_i.key_high;
  assign req.key_low      = in_i.key_low;
  assign req.request_size = in_i.request_size;

  kbfa_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .init_i      (init_q),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .req_i       (req),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .res_o       (res)
  );

  assign out_o.status        = res.status;
  assign out_o.slot_index    = res.slot_index;
  assign out_o.region_offset = res.region_offset;
  assign out_o.region_size   = res.region_size;

endmodule

[sv/kbfa_ram.sv]
// ----------------------------------------------------------------------------
// kbfa_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kbfa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] waddr_i,
  input  logic [Width-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] raddr_i,
  output logic [Width-1:0]                 rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[sv/kbfa_ctrl.sv]
// ----------------------------------------------------------------------------
// kbfa_ctrl
// Sequencer over the region table: key search, best-fit scan, merge and
// shift passes, visiting one table entry at a time.
// ----------------------------------------------------------------------------
module kbfa_ctrl #(
  parameter int unsigned SLOTS = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            init_i,
  input  kbfa_pkg::cfg_t  cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  kbfa_pkg::req_t  req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output kbfa_pkg::res_t  res_o
);
  import kbfa_pkg::*;

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned EW = $bits(entry_t);

  typedef enum logic [16:0] {
    S_IDLE     = 17'd1,
    S_FIND_RD  = 17'd2,
    S_FIND_CK  = 17'd4,
    S_DECIDE   = 17'd8,
    S_FA_CK    = 17'd16,
    S_FB_RD    = 17'd32,
    S_FB_CK    = 17'd64,
    S_DROP_RD  = 17'd128,
    S_DROP_WR  = 17'd256,
    S_AL_RD    = 17'd512,
    S_AL_CK    = 17'd1024,
    S_SH_RD    = 17'd2048,
    S_SH_WR    = 17'd4096,
    S_SPLIT_WR = 17'd8192,
    S_BEST_WR  = 17'd16384,
    S_EMIT     = 17'd32768,
    S_FREE_END = 17'd65536
  } state_e;

  state_e       state_q, state_d;
  req_t         req_q, req_d;
  logic [CW-1:0] n_q, n_d;
  logic         e0_fresh_q, e0_fresh_d;
  logic [CW-1:0] idx_q, idx_d;
  logic         found_q, found_d;
  logic [IW-1:0] slot_q, slot_d;
  entry_t       ent_q, ent_d;
  logic [IW-1:0] cur_idx_q, cur_idx_d;
  logic [30:0]  cur_off_q, cur_off_d;
  logic [30:0]  cur_size_q, cur_size_d;
  logic         ret_done_q, ret_done_d;
  logic         best_ok_q, best_ok_d;
  logic [IW-1:0] best_q, best_d;
  logic [30:0]  bdiff_q, bdiff_d;
  logic [30:0]  boff_q, boff_d;
  logic [30:0]  bsize_q, bsize_d;
  res_t         res_q, res_d;
  res_t         out_q, out_d;
  logic         out_valid_q, out_valid_d;
  logic [IW-1:0] raddr_q, raddr_d;

  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;
  entry_t        rd_ent;
  entry_t        init_ent;
  logic          key_zero;
  logic [30:0]   diff;

  kbfa_ram #(.Width(EW), .Depth(SLOTS)) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  function automatic entry_t mk_ent(logic [63:0] hi, logic [63:0] lo,
                                    logic [30:0] off, logic [30:0] sz);
    entry_t e;
    e.key_high = hi;
    e.key_low  = lo;
    e.offset   = off;
    e.size     = sz;
    return e;
  endfunction

  function automatic logic [5:0] slot6(logic [IW-1:0] idx);
    logic [IW+5:0] t;
    t = {{6{1'b0}}, idx};
    return t[5:0];
  endfunction

  function automatic res_t mk_res(status_e st, logic [5:0] sl, logic [30:0] off,
                                  logic [30:0] sz);
    res_t r;
    r.status        = st;
    r.slot_index    = sl;
    r.region_offset = off;
    r.region_size   = sz;
    return r;
  endfunction

  assign init_ent = mk_ent(64'd0, 64'd0, {10'd0, cfg_i.base_offset}, cfg_i.pool_size);
  assign rd_ent   = (raddr_q == '0 && e0_fresh_q) ? init_ent : entry_t'(ram_rdata);
  assign key_zero = (rd_ent.key_high == 64'd0) && (rd_ent.key_low == 64'd0);
  assign diff     = rd_ent.size - req_q.request_size;

  assign in_ready_o  = (state_q == S_IDLE) && !init_i;
  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    n_d         = n_q;
    e0_fresh_d  = e0_fresh_q;
    idx_d       = idx_q;
    found_d     = found_q;
    slot_d      = slot_q;
    ent_d       = ent_q;
    cur_idx_d   = cur_idx_q;
    cur_off_d   = cur_off_q;
    cur_size_d  = cur_size_q;
    ret_done_d  = ret_done_q;
    best_ok_d   = best_ok_q;
    best_d      = best_q;
    bdiff_d     = bdiff_q;
    boff_d      = boff_q;
    bsize_d     = bsize_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    raddr_d     = raddr_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          req_d   = req_i;
          idx_d   = '0;
          found_d = 1'b0;
          if ((req_i.key_high == 64'd0 && req_i.key_low == 64'd0) ||
              !(req_i.func inside {FN_LOOKUP, FN_STORE, FN_REMOVE}) ||
              (req_i.func == FN_STORE && req_i.request_size == 31'd0)) begin
            res_d   = mk_res(ST_BAD, 6'd0, 31'd0, 31'd0);
            state_d = S_EMIT;
          end else begin
            state_d = S_FIND_RD;
          end
        end
      end
      S_FIND_RD: begin
        if (idx_q < n_q) begin
          ram_re    = 1'b1;
          ram_raddr = idx_q[IW-1:0];
          raddr_d   = idx_q[IW-1:0];
          state_d   = S_FIND_CK;
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_FIND_CK: begin
        if (rd_ent.key_high == req_q.key_high && rd_ent.key_low == req_q.key_low) begin
          found_d = 1'b1;
          slot_d  = idx_q[IW-1:0];
          ent_d   = rd_ent;
          state_d = S_DECIDE;
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = S_FIND_RD;
        end
      end
      S_DECIDE: begin
        cur_idx_d  = slot_q;
        cur_off_d  = ent_q.offset;
        cur_size_d = ent_q.size;
        idx_d      = '0;
        best_ok_d  = 1'b0;
        if (!found_q) begin
          if (req_q.func == FN_STORE) begin
            state_d = S_AL_RD;
          end else begin
            res_d   = mk_res(ST_NOT_FOUND, 6'd0, 31'd0, 31'd0);
            state_d = S_EMIT;
          end
        end else if (req_q.func == FN_LOOKUP) begin
          res_d = mk_res((req_q.request_size > ent_q.size) ? ST_TOO_LARGE : ST_OK,
                         slot6(slot_q), ent_q.offset, ent_q.size);
          state_d = S_EMIT;
        end else if (req_q.func == FN_STORE && ent_q.size >= req_q.request_size) begin
          res_d   = mk_res(ST_OK, slot6(slot_q), ent_q.offset, ent_q.size);
          state_d = S_EMIT;
        end else begin
          res_d = mk_res(ST_OK, slot6(slot_q), ent_q.offset, ent_q.size);
          if (slot_q != '0) begin
            ram_re    = 1'b1;
            ram_raddr = slot_q - IW'(1);
            raddr_d   = slot_q - IW'(1);
            state_d   = S_FA_CK;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = slot_q;
            ram_wdata = mk_ent(64'd0, 64'd0, ent_q.offset, ent_q.size);
            state_d   = S_FB_RD;
          end
        end
      end
      S_FA_CK: begin
        ram_we = 1'b1;
        if (key_zero) begin
          ram_waddr  = slot_q - IW'(1);
          ram_wdata  = mk_ent(64'd0, 64'd0, rd_ent.offset, rd_ent.size + cur_size_q);
          cur_idx_d  = slot_q - IW'(1);
          cur_off_d  = rd_ent.offset;
          cur_size_d = rd_ent.size + cur_size_q;
          idx_d      = CW'(slot_q) + CW'(1);
          ret_done_d = 1'b0;
          state_d    = S_DROP_RD;
        end else begin
          ram_waddr = cur_idx_q;
          ram_wdata = mk_ent(64'd0, 64'd0, cur_off_q, cur_size_q);
          state_d   = S_FB_RD;
        end
      end
      S_FB_RD: begin
        if (CW'(cur_idx_q) + CW'(1) < n_q) begin
          ram_re    = 1'b1;
          ram_raddr = cur_idx_q + IW'(1);
          raddr_d   = cur_idx_q + IW'(1);
          state_d   = S_FB_CK;
        end else begin
          state_d = S_FREE_END;
        end
      end
      S_FB_CK: begin
        if (key_zero) begin
          ram_we     = 1'b1;
          ram_waddr  = cur_idx_q;
          ram_wdata  = mk_ent(64'd0, 64'd0, cur_off_q, cur_size_q + rd_ent.size);
          idx_d      = CW'(cur_idx_q) + CW'(2);
          ret_done_d = 1'b1;
          state_d    = S_DROP_RD;
        end else begin
          state_d = S_FREE_END;
        end
      end
      S_DROP_RD: begin
        if (idx_q < n_q) begin
          ram_re    = 1'b1;
          ram_raddr = idx_q[IW-1:0];
          raddr_d   = idx_q[IW-1:0];
          state_d   = S_DROP_WR;
        end else begin
          n_d     = n_q - CW'(1);
          state_d = ret_done_q ? S_FREE_END : S_FB_RD;
        end
      end
      S_DROP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = IW'(idx_q - CW'(1));
        ram_wdata = rd_ent;
        idx_d     = idx_q + CW'(1);
        state_d   = S_DROP_RD;
      end
      S_FREE_END: begin
        idx_d     = '0;
        best_ok_d = 1'b0;
        state_d   = (req_q.func == FN_REMOVE) ? S_EMIT : S_AL_RD;
      end
      S_AL_RD: begin
        if (idx_q < n_q) begin
          ram_re    = 1'b1;
          ram_raddr = idx_q[IW-1:0];
          raddr_d   = idx_q[IW-1:0];
          state_d   = S_AL_CK;
        end else if (!best_ok_q) begin
          res_d   = mk_res(ST_NO_SPACE, 6'd0, 31'd0, 31'd0);
          state_d = S_EMIT;
        end else if (bdiff_q != 31'd0 && bdiff_q >= cfg_i.split_threshold &&
                     n_q < CW'(SLOTS)) begin
          idx_d   = n_q;
          state_d = S_SH_RD;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = best_q;
          ram_wdata = mk_ent(req_q.key_high, req_q.key_low, boff_q, bsize_q);
          res_d     = mk_res(ST_OK, slot6(best_q), boff_q, bsize_q);
          state_d   = S_EMIT;
        end
      end
      S_AL_CK: begin
        if (key_zero && rd_ent.size >= req_q.request_size &&
            (!best_ok_q || diff < bdiff_q)) begin
          best_ok_d = 1'b1;
          best_d    = idx_q[IW-1:0];
          bdiff_d   = diff;
          boff_d    = rd_ent.offset;
          bsize_d   = rd_ent.size;
        end
        idx_d   = idx_q + CW'(1);
        state_d = S_AL_RD;
      end
      S_SH_RD: begin
        if (idx_q > CW'(best_q) + CW'(1)) begin
          ram_re    = 1'b1;
          ram_raddr = IW'(idx_q - CW'(1));
          raddr_d   = IW'(idx_q - CW'(1));
          state_d   = S_SH_WR;
        end else begin
          state_d = S_SPLIT_WR;
        end
      end
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[IW-1:0];
        ram_wdata = rd_ent;
        idx_d     = idx_q - CW'(1);
        state_d   = S_SH_RD;
      end
      S_SPLIT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = best_q + IW'(1);
        ram_wdata = mk_ent(64'd0, 64'd0, boff_q + req_q.request_size, bdiff_q);
        state_d   = S_BEST_WR;
      end
      S_BEST_WR: begin
        ram_we    = 1'b1;
        ram_waddr = best_q;
        ram_wdata = mk_ent(req_q.key_high, req_q.key_low, boff_q, req_q.request_size);
        n_d       = n_q + CW'(1);
        res_d     = mk_res(ST_OK, slot6(best_q), boff_q, req_q.request_size);
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (ram_we && ram_waddr == '0) begin
      e0_fresh_d = 1'b0;
    end
    if (init_i) begin
      e0_fresh_d = 1'b1;
      n_d        = (cfg_i.pool_size != 31'd0) ? CW'(1) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= CW'(1);
      e0_fresh_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      e0_fresh_q  <= e0_fresh_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    idx_q      <= idx_d;
    found_q    <= found_d;
    slot_q     <= slot_d;
    ent_q      <= ent_d;
    cur_idx_q  <= cur_idx_d;
    cur_off_q  <= cur_off_d;
    cur_size_q <= cur_size_d;
    ret_done_q <= ret_done_d;
    best_ok_q  <= best_ok_d;
    best_q     <= best_d;
    bdiff_q    <= bdiff_d;
    boff_q     <= boff_d;
    bsize_q    <= bsize_d;
    res_q      <= res_d;
    out_q      <= out_d;
    raddr_q    <= raddr_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CW'(SLOTS))
    else $error("table entry count exceeds slot count");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("table read and write hit the same entry");

  a_split_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BEST_WR && !init_i) |=> (n_q == $past(n_q) + CW'(1)))
    else $error("split did not add a table entry");

  a_fresh_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(e0_fresh_q) |-> $past(ram_we && ram_waddr == '0))
    else $error("first entry left its reset value without a write");

endmodule
